// ===== design/mtfc_pkg.sv =====
// Package for the move-to-front codec: payload structs, cell control types and constants.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps

package mtfc_pkg;

  localparam int LIST_SIZE = 256;
  localparam int RUN_W = 25;
  localparam logic [RUN_W-1:0] BLOCK_BYTES = 25'd16777216;

  localparam logic CFG_DIRECTION = 1'b0;
  localparam logic CFG_ZERO_RUN = 1'b1;

  localparam logic KIND_VALUE = 1'b0;
  localparam logic KIND_RUN = 1'b1;

  typedef struct packed {
    logic [7:0] symbol;
    logic       block_start;
    logic       block_end;
  } mtfc_in_t;

  typedef struct packed {
    logic             item_kind;
    logic [7:0]       value;
    logic [RUN_W-1:0] run_length;
    logic             last;
  } mtfc_out_t;

  typedef struct packed {
    logic       use_identity;
    logic       move;
    logic [7:0] sym;
    logic [7:0] pos;
    logic [7:0] front;
  } mtfc_cell_ctrl_t;

  typedef struct packed {
    logic [7:0] eff;
    logic       match;
    logic [7:0] sel;
  } mtfc_cell_stat_t;

  typedef struct packed {
    logic [7:0] pos;
    logic [7:0] byte_val;
  } mtfc_found_t;

endpackage

// ===== design/mtfc_cell.sv =====
// One entry of the rank list: holds a byte, compares it and takes its neighbor's byte on a move.
// Depends on mtfc_pkg.
`timescale 1ns / 1ps

module mtfc_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [7:0]               idx,
  input  mtfc_pkg::mtfc_cell_ctrl_t ctrl,
  input  logic [7:0]               prev,
  output mtfc_pkg::mtfc_cell_stat_t stat
);
  import mtfc_pkg::*;

  logic [7:0] data_r;
  logic [7:0] data_nxt;
  logic [7:0] eff;

  assign eff = ctrl.use_identity ? idx : data_r;
  assign data_nxt = (idx <= ctrl.pos) ? prev : eff;

  assign stat.eff = eff;
  assign stat.match = (eff == ctrl.sym);
  assign stat.sel = (idx == ctrl.sym) ? eff : 8'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r <= idx;
    end else if (ctrl.move) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ===== design/mtfc_array.sv =====
// Row of rank list cells with the OR trees that report the found position and byte.
// Depends on mtfc_pkg and mtfc_cell.
`timescale 1ns / 1ps

module mtfc_array (
  input  logic                      clk,
  input  logic                      rst_n,
  input  mtfc_pkg::mtfc_cell_ctrl_t ctrl,
  output mtfc_pkg::mtfc_found_t     found
);
  import mtfc_pkg::*;

  mtfc_cell_stat_t stat [LIST_SIZE];

  for (genvar gi = 0; gi < LIST_SIZE; gi++) begin : g_cell
    logic [7:0] prev;
    if (gi == 0) begin : g_head
      assign prev = ctrl.front;
    end else begin : g_body
      assign prev = stat[gi-1].eff;
    end
    mtfc_cell u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .idx  (8'(gi)),
      .ctrl (ctrl),
      .prev (prev),
      .stat (stat[gi])
    );
  end

  always_comb begin
    found = '0;
    for (int i = 0; i < LIST_SIZE; i++) begin
      found.pos = found.pos | (stat[i].match ? 8'(i) : 8'd0);
      found.byte_val = found.byte_val | stat[i].sel;
    end
  end

endmodule

// ===== design/move_to_front_codec_unit.sv =====
// Top level of the move-to-front codec: request sequencing, zero run counting, result output.
// Depends on mtfc_pkg and mtfc_array.
//
// Usage. An input request carries a symbol (a byte to encode or a rank to decode) with
// block_start and block_end flags. The block accepts one request at a time: in_ready is high
// only while no request is in progress. The cycle after acceptance searches the rank list
// through the cell row and OR trees; the next cycle shifts the cells and moves the byte to
// the front while the results are formed. A request gives zero, one or two results, which
// appear on the output channel one after another, the last one flagged.
// From acceptance a request passes through the find and move states before its first result is
// shown; a request with no result returns to idle straight from the move state.
// A stalled receiver holds the block: the waiting result stays on out_data unchanged and no
// new request is taken until all results of the current one are accepted.
// Configuration must be written through cfg_we, cfg_index and cfg_data only while the block
// is idle; the block itself does not enforce this. Reset sets the rank list to identity,
// clears the run count, selects encode without zero runs and leaves the block idle and ready.
`timescale 1ns / 1ps

module move_to_front_codec_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mtfc_pkg::mtfc_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mtfc_pkg::mtfc_out_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic                cfg_data
);
  import mtfc_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_FIND = 5'b00010,
    S_MOVE = 5'b00100,
    S_OUT0 = 5'b01000,
    S_OUT1 = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic             direction_r, zero_run_r;
  logic [7:0]       sym_r;
  logic             bstart_r, bend_r;
  logic [7:0]       pos_r, byte_r;
  logic [RUN_W-1:0] run_r, run_nxt;
  mtfc_out_t        res0_r, res1_r;
  logic             two_r;
  mtfc_out_t        res [2];
  logic [1:0]       nres;
  logic [RUN_W-1:0] cnt;

  mtfc_cell_ctrl_t ctrl;
  mtfc_found_t     found;

  assign ctrl.use_identity = bstart_r;
  assign ctrl.move = (state_r == S_MOVE);
  assign ctrl.sym = sym_r;
  assign ctrl.pos = pos_r;
  assign ctrl.front = byte_r;

  mtfc_array u_array (
    .clk  (clk),
    .rst_n(rst_n),
    .ctrl (ctrl),
    .found(found)
  );

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT0) || (state_r == S_OUT1);
  assign out_data = (state_r == S_OUT1) ? res1_r : res0_r;

  always_comb begin
    cnt = bstart_r ? '0 : run_r;
    nres = 2'd0;
    res[0] = '0;
    res[1] = '0;
    if (direction_r) begin
      res[0].value = byte_r;
      nres = 2'd1;
    end else if (!zero_run_r) begin
      res[0].value = pos_r;
      nres = 2'd1;
    end else begin
      if (pos_r == 8'd0) begin
        if (cnt == '0) begin
          res[0].item_kind = KIND_VALUE;
          nres = 2'd1;
        end
        if (cnt < BLOCK_BYTES) begin
          cnt = cnt + 1'b1;
        end
      end else begin
        if (cnt != '0) begin
          res[0].item_kind = KIND_RUN;
          res[0].run_length = cnt;
          nres = 2'd1;
        end
        cnt = '0;
        res[nres[0]].item_kind = KIND_VALUE;
        res[nres[0]].value = pos_r;
        nres = nres + 2'd1;
      end
      if (bend_r && (cnt != '0)) begin
        res[nres[0]].item_kind = KIND_RUN;
        res[nres[0]].value = 8'd0;
        res[nres[0]].run_length = cnt;
        nres = nres + 2'd1;
        cnt = '0;
      end
    end
    if (nres == 2'd2) begin
      res[1].last = 1'b1;
    end else begin
      res[0].last = 1'b1;
    end
    run_nxt = cnt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_FIND;
      end
      S_FIND: state_nxt = S_MOVE;
      S_MOVE: state_nxt = (nres == 2'd0) ? S_IDLE : S_OUT0;
      S_OUT0: begin
        if (out_ready) state_nxt = two_r ? S_OUT1 : S_IDLE;
      end
      S_OUT1: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      direction_r <= 1'b0;
      zero_run_r <= 1'b0;
      run_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_DIRECTION: direction_r <= cfg_data;
          CFG_ZERO_RUN:  zero_run_r <= cfg_data;
          default: ;
        endcase
      end
      if (state_r == S_MOVE) begin
        run_r <= run_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sym_r <= in_data.symbol;
      bstart_r <= in_data.block_start;
      bend_r <= in_data.block_end;
    end
    if (state_r == S_FIND) begin
      pos_r <= direction_r ? sym_r : found.pos;
      byte_r <= direction_r ? found.byte_val : sym_r;
    end
    if (state_r == S_MOVE) begin
      res0_r <= res[0];
      res1_r <= res[1];
      two_r <= (nres == 2'd2);
    end
  end

endmodule

// ===== design/mtfc_checker.sv =====
// Port-level checks for the move-to-front codec, bound to the top level.
// Depends on mtfc_pkg and move_to_front_codec_unit.
`timescale 1ns / 1ps

module mtfc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input mtfc_pkg::mtfc_out_t out_data
);
  import mtfc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("Stalled result changed or dropped.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready && !out_valid)
    else $error("Block not busy after taking a request.");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("Request taken while a result is pending.");

  a_run_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.item_kind == KIND_RUN) |->
      (out_data.value == 8'd0) && (out_data.run_length != '0) &&
      (out_data.run_length <= BLOCK_BYTES))
    else $error("Malformed run length result.");

endmodule

bind move_to_front_codec_unit mtfc_checker u_mtfc_checker (.*);
